// ----- rtl/ppr_pkg.sv -----
// Shared types, codes and widths of the per-process page replacement block.
package ppr_pkg;

  localparam int PID_W      = 3;
  localparam int PAGE_W     = 10;
  localparam int FC_W       = 4;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 3;

  localparam int PROCESSES_DEF  = 8;
  localparam int MAX_FRAMES_DEF = 8;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_OPEN   = 2'd1,
    OP_CLOSE  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_FILL   = 3'd1,
    ST_EVICT  = 3'd2,
    ST_NOPROC = 3'd3,
    ST_DONE   = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t           op;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic [FC_W-1:0]   fc;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [PAGE_W-1:0]     evicted_page;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic open_set;
    logic open_clr;
  } ctl_t;

endpackage

// ----- rtl/ppr_ctx_mem.sv -----
// Context memory: one wide word per process, one write and one registered read port.
module ppr_ctx_mem #(
  parameter int DEPTH  = ppr_pkg::PROCESSES_DEF,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ppr_update.sv -----
// Context update: slot search, victim choice and recency update of one request.
module ppr_update #(
  parameter int MAX_FRAMES = ppr_pkg::MAX_FRAMES_DEF,
  parameter int CNT_W      = $clog2(MAX_FRAMES + 1),
  parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  ppr_pkg::req_t                                  req,
  input  logic                                           pid_ok,
  input  logic                                           ctx_open,
  input  logic                                           policy,
  input  logic [CNT_W-1:0]                               granted,
  input  logic [CNT_W-1:0]                               filled,
  input  logic [SLOT_W-1:0]                              ptr,
  input  logic [MAX_FRAMES-1:0][ppr_pkg::PAGE_W-1:0]     pages,
  input  logic [MAX_FRAMES-1:0][SLOT_W-1:0]              ranks,
  output ppr_pkg::ctl_t                                  ctl,
  output ppr_pkg::res_t                                  res,
  output logic [CNT_W-1:0]                               granted_nxt,
  output logic [CNT_W-1:0]                               filled_nxt,
  output logic [SLOT_W-1:0]                              ptr_nxt,
  output logic [MAX_FRAMES-1:0][ppr_pkg::PAGE_W-1:0]     pages_nxt,
  output logic [MAX_FRAMES-1:0][SLOT_W-1:0]              ranks_nxt
);

  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] lru_idx;
  logic [SLOT_W-1:0] fifo_vic;
  logic [SLOT_W-1:0] fifo_adv;
  logic [SLOT_W-1:0] sel;
  logic [SLOT_W-1:0] limit;
  logic              lim_all;
  logic              has_room;
  logic [CNT_W-1:0]  fc_clamped;

  // Parallel compare across all filled slots; ranks are distinct, so the
  // least recent slot is the one whose rank equals filled - 1.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    lru_idx = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (k < filled) begin
        if (!hit && pages[k] == req.page) begin
          hit     = 1'b1;
          hit_idx = SLOT_W'(k);
        end
        if (CNT_W'(ranks[k]) == filled - CNT_W'(1)) begin
          lru_idx = SLOT_W'(k);
        end
      end
    end
  end

  always_comb begin
    fifo_vic = (CNT_W'(ptr) >= granted) ? '0 : ptr;
    fifo_adv = (CNT_W'(fifo_vic) + CNT_W'(1) < granted) ? fifo_vic + SLOT_W'(1) : '0;
    has_room = filled < granted;
    if (req.fc == '0) begin
      fc_clamped = CNT_W'(1);
    end else if (req.fc > MAX_FRAMES) begin
      fc_clamped = CNT_W'(MAX_FRAMES);
    end else begin
      fc_clamped = CNT_W'(req.fc);
    end
  end

  // Slot touched by the access and the rank limit for aging the others.
  always_comb begin
    if (hit) begin
      sel     = hit_idx;
      limit   = ranks[hit_idx];
      lim_all = 1'b0;
    end else if (has_room) begin
      sel     = SLOT_W'(filled);
      limit   = '0;
      lim_all = 1'b1;
    end else begin
      sel     = policy ? fifo_vic : lru_idx;
      limit   = ranks[sel];
      lim_all = 1'b0;
    end
  end

  always_comb begin
    ctl              = '0;
    res.status       = ppr_pkg::ST_NOPROC;
    res.slot         = '0;
    res.evicted_page = '0;
    granted_nxt      = granted;
    filled_nxt       = filled;
    ptr_nxt          = ptr;
    pages_nxt        = pages;
    ranks_nxt        = ranks;
    if (pid_ok) begin
      case (req.op)
        ppr_pkg::OP_OPEN: begin
          ctl.wr_en    = 1'b1;
          ctl.open_set = 1'b1;
          granted_nxt  = fc_clamped;
          filled_nxt   = '0;
          ptr_nxt      = '0;
          res.status   = ppr_pkg::ST_DONE;
        end
        ppr_pkg::OP_CLOSE: begin
          if (ctx_open) begin
            ctl.wr_en    = 1'b1;
            ctl.open_clr = 1'b1;
            granted_nxt  = '0;
            filled_nxt   = '0;
            ptr_nxt      = '0;
            res.status   = ppr_pkg::ST_DONE;
          end
        end
        ppr_pkg::OP_ACCESS: begin
          if (ctx_open) begin
            ctl.wr_en = 1'b1;
            res.slot  = ppr_pkg::OUT_SLOT_W'(sel);
            if (hit) begin
              res.status = ppr_pkg::ST_HIT;
            end else if (has_room) begin
              res.status = ppr_pkg::ST_FILL;
              filled_nxt = filled + CNT_W'(1);
            end else begin
              res.status       = ppr_pkg::ST_EVICT;
              res.evicted_page = pages[sel];
              if (policy) begin
                ptr_nxt = fifo_adv;
              end
            end
            for (int k = 0; k < MAX_FRAMES; k++) begin
              if (SLOT_W'(k) == sel) begin
                ranks_nxt[k] = '0;
                if (!hit) begin
                  pages_nxt[k] = req.page;
                end
              end else if (k < filled && (lim_all || ranks[k] < limit)) begin
                ranks_nxt[k] = ranks[k] + SLOT_W'(1);
              end
            end
          end
        end
        default: begin
          res.status = ppr_pkg::ST_NOPROC;
        end
      endcase
    end
  end

endmodule

// ----- rtl/per_process_page_replacement_top.sv -----
// Top level of the per-process page replacement block.
//
// Input channel (in_valid/in_ready) carries one request: an opcode, a process
// id, a page and a frame count. Result channel (out_valid/out_ready) returns
// one item per request: status, slot and evicted page.
// cfg_wr_en writes the replacement policy (0 LRU, 1 FIFO) in the same cycle;
// change it only while the block is idle and no process is open.
//
// The accept edge reads the process's context word from the context memory;
// in the execute state the block compares all slots in parallel, writes
// the word back and loads the result register, and out_valid rises as
// that step completes. A new request is taken only after the last one
// has left the execute state. in_ready is high whenever no request is in
// flight; a held result does not block acceptance, but the next request
// waits in the execute state until the result register frees.
// Reset clears the open flag of every process, the policy and both
// handshakes; the context memory needs no clearing pass.
module per_process_page_replacement_top #(
  parameter int PROCESSES  = ppr_pkg::PROCESSES_DEF,
  parameter int MAX_FRAMES = ppr_pkg::MAX_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_replacement_policy,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [ppr_pkg::PID_W-1:0]       in_process_id,
  input  logic [ppr_pkg::PAGE_W-1:0]      in_page,
  input  logic [ppr_pkg::FC_W-1:0]        in_frame_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ppr_pkg::STATUS_W-1:0]    out_status,
  output logic [ppr_pkg::OUT_SLOT_W-1:0]  out_slot,
  output logic [ppr_pkg::PAGE_W-1:0]      out_evicted_page
);

  localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int WORD_W = 2 * CNT_W + SLOT_W + MAX_FRAMES * (ppr_pkg::PAGE_W + SLOT_W);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                 state_r;
  ppr_pkg::req_t          req_r;
  logic [PROCESSES-1:0]   open_r;
  logic                   policy_r;
  logic                   out_valid_r;
  ppr_pkg::res_t          res_r;

  logic                   in_fire;
  logic                   exec_fire;
  logic                   pid_ok;
  logic [PIDX_W-1:0]      req_idx;
  logic [PIDX_W-1:0]      rd_addr;
  logic [WORD_W-1:0]      rd_word;
  logic [WORD_W-1:0]      wr_word;
  logic                   mem_we;

  logic [CNT_W-1:0]                              granted, granted_nxt;
  logic [CNT_W-1:0]                              filled, filled_nxt;
  logic [SLOT_W-1:0]                             ptr, ptr_nxt;
  logic [MAX_FRAMES-1:0][ppr_pkg::PAGE_W-1:0]    pages, pages_nxt;
  logic [MAX_FRAMES-1:0][SLOT_W-1:0]             ranks, ranks_nxt;

  ppr_pkg::ctl_t          ctl;
  ppr_pkg::res_t          res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign req_idx = PIDX_W'(req_r.pid);
  assign pid_ok  = req_r.pid < PROCESSES;
  // Keep the read on the pending request while it waits, so the data holds.
  assign rd_addr = in_fire ? PIDX_W'(in_process_id) : req_idx;
  assign mem_we  = exec_fire && ctl.wr_en;

  assign {granted, filled, ptr, pages, ranks} = rd_word;
  assign wr_word = {granted_nxt, filled_nxt, ptr_nxt, pages_nxt, ranks_nxt};

  ppr_ctx_mem #(
    .DEPTH  (PROCESSES),
    .WIDTH  (WORD_W),
    .ADDR_W (PIDX_W)
  ) u_ctx_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (req_idx),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  ppr_update #(
    .MAX_FRAMES (MAX_FRAMES),
    .CNT_W      (CNT_W),
    .SLOT_W     (SLOT_W)
  ) u_update (
    .req         (req_r),
    .pid_ok      (pid_ok),
    .ctx_open    (pid_ok && open_r[req_idx]),
    .policy      (policy_r),
    .granted     (granted),
    .filled      (filled),
    .ptr         (ptr),
    .pages       (pages),
    .ranks       (ranks),
    .ctl         (ctl),
    .res         (res),
    .granted_nxt (granted_nxt),
    .filled_nxt  (filled_nxt),
    .ptr_nxt     (ptr_nxt),
    .pages_nxt   (pages_nxt),
    .ranks_nxt   (ranks_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      policy_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy_r <= cfg_replacement_policy;
      end
      if (out_valid_r && out_ready && !exec_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (ctl.open_set) begin
              open_r[req_idx] <= 1'b1;
            end
            if (ctl.open_clr) begin
              open_r[req_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= '{op: ppr_pkg::opcode_t'(in_opcode), pid: in_process_id,
                 page: in_page, fc: in_frame_count};
    end
    if (exec_fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_slot         = res_r.slot;
  assign out_evicted_page = res_r.evicted_page;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in flight");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EXEC))
    else $error("result raised outside the execute step");

  a_mem_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_EXEC && (!out_valid_r || out_ready))
    else $error("context written outside a completing execute step");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ppr_pkg::ST_DONE || out_status == ppr_pkg::ST_NOPROC)
    |-> out_slot == '0 && out_evicted_page == '0)
    else $error("slot or evicted page set on a non-access result");
`endif

endmodule
